// ===== sv/sdg_pkg.sv =====
// Shared constants, types and helpers for the signed distance grid block.
package sdg_pkg;

  localparam int GRID_X_MAX = 64;
  localparam int GRID_Y_MAX = 64;
  localparam int GRID_Z_MAX = 64;
  localparam int OWNER_BITS = 24;

  localparam int CELLS  = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = 6;
  localparam int EXT_W  = 7;

  localparam int COORD_W = 24;
  localparam int RAD_W   = 12;
  localparam int SPC_W   = 12;
  localparam int CFG_W   = 3;
  localparam int DATA_W  = 24;
  localparam int DIST_W  = 16;
  localparam int OWN_W   = 25;
  localparam int ENTRY_W = DIST_W + OWN_W;

  localparam int D_W     = 27;  // offset from center along one axis
  localparam int REACH_W = 15;  // radius plus three spacings
  localparam int MAG_W   = 14;  // offset magnitude inside the box
  localparam int SQR_W   = 2 * MAG_W;
  localparam int SQ_W    = 30;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int CNT_W   = 4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SPLAT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [CFG_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_W-1:0] CFG_SPACING  = 3'd3;
  localparam logic [CFG_W-1:0] CFG_EXTENT_X = 3'd4;
  localparam logic [CFG_W-1:0] CFG_EXTENT_Y = 3'd5;
  localparam logic [CFG_W-1:0] CFG_EXTENT_Z = 3'd6;

  localparam logic [1:0] ADDR_BOX = 2'd0;
  localparam logic [1:0] ADDR_CLR = 2'd1;
  localparam logic [1:0] ADDR_RD  = 2'd2;

  localparam logic signed [DIST_W-1:0] EMPTY_DIST = 16'sh7FFF;
  localparam logic [OWN_W-1:0]         NO_OWNER   = {OWN_W{1'b1}};

  typedef struct packed {
    logic       clr_init;
    logic       clr_step;
    logic       load;
    logic [2:0] find_step;
    logic       lock;
    logic       square;
    logic       sum;
    logic       root_step;
    logic       write;
    logic       step_z;
    logic       step_y;
    logic       step_x;
    logic [1:0] addr_sel;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [2:0] in_box;
    logic [2:0] past;
    logic [2:0] last;
    logic [2:0] more;
  } status_t;

  function automatic logic [EXT_W-1:0] eff_extent(logic [EXT_W-1:0] e,
                                                  logic [EXT_W-1:0] m);
    logic [EXT_W-1:0] r;
    r = e;
    if (e == '0) r = EXT_W'(1);
    else if (e > m) r = m;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [IDX_W-1:0] x,
                                                  logic [IDX_W-1:0] y,
                                                  logic [IDX_W-1:0] z);
    return ADDR_W'((int'(x) * GRID_Y_MAX + int'(y)) * GRID_Z_MAX + int'(z));
  endfunction

endpackage

// ===== sv/sdg_ctrl.sv =====
// Controller state machine for the signed distance grid block.
module sdg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       op,
  input  sdg_pkg::status_t st,
  output sdg_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_FIND = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_ADV  = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state, state_next;
  logic [sdg_pkg::CNT_W-1:0] count, count_next;
  logic [2:0] below;

  assign below = ~st.in_box & ~st.past;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    cmd.addr_sel = sdg_pkg::ADDR_BOX;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            sdg_pkg::OP_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_next = S_CLR;
            end
            sdg_pkg::OP_SPLAT: begin
              cmd.load = 1'b1;
              state_next = S_FIND;
            end
            sdg_pkg::OP_READ: begin
              cmd.load = 1'b1;
              state_next = S_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.addr_sel = sdg_pkg::ADDR_CLR;
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_FIND: begin
        // An axis whose range misses the grid leaves nothing to visit.
        if ((|st.past) || (|(below & st.last))) begin
          state_next = S_IDLE;
        end else if (&st.in_box) begin
          cmd.lock = 1'b1;
          state_next = S_SQ;
        end else begin
          cmd.find_step = below;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        count_next = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        count_next = count + 1'b1;
        if (count == sdg_pkg::CNT_W'(sdg_pkg::ROOT_W - 1)) state_next = S_CMP;
      end
      S_CMP: begin
        cmd.write = 1'b1;
        state_next = S_ADV;
      end
      S_ADV: begin
        state_next = S_SQ;
        if (st.more[2]) cmd.step_z = 1'b1;
        else if (st.more[1]) cmd.step_y = 1'b1;
        else if (st.more[0]) cmd.step_x = 1'b1;
        else state_next = S_IDLE;
      end
      S_RD: begin
        cmd.addr_sel = sdg_pkg::ADDR_RD;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

endmodule

// ===== sv/sdg_dp.sv =====
// Datapath: configuration, box walk, squared distance, square root and grid memory.
module sdg_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sdg_pkg::cmd_t                        cmd,
  output sdg_pkg::status_t                     st,
  input  logic                                 cfg_valid,
  input  logic [sdg_pkg::CFG_W-1:0]            cfg_index,
  input  logic [sdg_pkg::DATA_W-1:0]           cfg_data,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_x,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_y,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_z,
  input  logic [sdg_pkg::RAD_W-1:0]            ball_radius,
  input  logic [sdg_pkg::OWNER_BITS-1:0]       ball_owner,
  input  logic [sdg_pkg::IDX_W-1:0]            read_x,
  input  logic [sdg_pkg::IDX_W-1:0]            read_y,
  input  logic [sdg_pkg::IDX_W-1:0]            read_z,
  output logic signed [sdg_pkg::DIST_W-1:0]    cell_distance,
  output logic signed [sdg_pkg::OWN_W-1:0]     cell_owner
);

  localparam int DW = sdg_pkg::D_W;

  logic signed [sdg_pkg::COORD_W-1:0] origin [3];
  logic [sdg_pkg::EXT_W-1:0] extent [3];
  logic [sdg_pkg::SPC_W-1:0] spacing;

  logic [sdg_pkg::EXT_W-1:0] eff [3];
  logic [sdg_pkg::SPC_W-1:0] step;
  logic signed [DW-1:0] step_s, reach_s;

  logic [sdg_pkg::IDX_W-1:0] idx [3];
  logic [sdg_pkg::IDX_W-1:0] lo_idx [3];
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] lo_d [3];
  logic [sdg_pkg::RAD_W-1:0] radius;
  logic [sdg_pkg::OWNER_BITS-1:0] owner;
  logic [sdg_pkg::IDX_W-1:0] rx, ry, rz;
  logic rd_ok;

  logic [sdg_pkg::SQR_W-1:0] sqr [3];
  logic [sdg_pkg::SQ_W-1:0] rad;
  logic [sdg_pkg::ROOT_W-1:0] root;
  logic [sdg_pkg::REM_W-1:0] rem;
  logic [sdg_pkg::REM_W-1:0] rem_t, trial;

  logic [sdg_pkg::ADDR_W-1:0] clr_cnt, addr;
  logic [sdg_pkg::ENTRY_W-1:0] mem [sdg_pkg::CELLS];
  logic [sdg_pkg::ENTRY_W-1:0] rd_data, wdata;
  logic we;

  logic [sdg_pkg::ROOT_W:0] q_round;
  logic signed [sdg_pkg::ROOT_W+1:0] val;
  logic signed [sdg_pkg::DIST_W-1:0] val_sat;
  logic better;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      spacing   <= sdg_pkg::SPC_W'(128);
      extent[0] <= sdg_pkg::EXT_W'(64);
      extent[1] <= sdg_pkg::EXT_W'(64);
      extent[2] <= sdg_pkg::EXT_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdg_pkg::CFG_ORIGIN_X: origin[0] <= cfg_data;
        sdg_pkg::CFG_ORIGIN_Y: origin[1] <= cfg_data;
        sdg_pkg::CFG_ORIGIN_Z: origin[2] <= cfg_data;
        sdg_pkg::CFG_SPACING:  spacing   <= cfg_data[sdg_pkg::SPC_W-1:0];
        sdg_pkg::CFG_EXTENT_X: extent[0] <= cfg_data[sdg_pkg::EXT_W-1:0];
        sdg_pkg::CFG_EXTENT_Y: extent[1] <= cfg_data[sdg_pkg::EXT_W-1:0];
        sdg_pkg::CFG_EXTENT_Z: extent[2] <= cfg_data[sdg_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff[0] = sdg_pkg::eff_extent(extent[0], sdg_pkg::EXT_W'(sdg_pkg::GRID_X_MAX));
  assign eff[1] = sdg_pkg::eff_extent(extent[1], sdg_pkg::EXT_W'(sdg_pkg::GRID_Y_MAX));
  assign eff[2] = sdg_pkg::eff_extent(extent[2], sdg_pkg::EXT_W'(sdg_pkg::GRID_Z_MAX));
  assign step   = (spacing == '0) ? sdg_pkg::SPC_W'(1) : spacing;
  assign step_s = $signed(DW'(step));
  // A cell lies in the widened box exactly when its offset magnitude is below r + 3s.
  assign reach_s = $signed(DW'(DW'(radius) + DW'(3) * DW'(step)));

  always_comb begin
    st = '0;
    st.clr_last = (clr_cnt == sdg_pkg::ADDR_W'(sdg_pkg::CELLS - 1));
    for (int a = 0; a < 3; a++) begin
      st.in_box[a] = (d[a] > -reach_s) && (d[a] < reach_s);
      st.past[a]   = (d[a] >= reach_s);
      st.last[a]   = ({1'b0, idx[a]} == eff[a] - 1'b1);
      st.more[a]   = !st.last[a] && ((d[a] + step_s) < reach_s);
    end
  end

  // Item registers and the box walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radius <= ball_radius;
      owner  <= ball_owner;
      rx <= read_x;
      ry <= read_y;
      rz <= read_z;
      rd_ok <= ({1'b0, read_x} < eff[0]) && ({1'b0, read_y} < eff[1]) &&
               ({1'b0, read_z} < eff[2]);
      idx[0] <= '0;
      idx[1] <= '0;
      idx[2] <= '0;
      d[0] <= DW'(origin[0]) - DW'(center_x);
      d[1] <= DW'(origin[1]) - DW'(center_y);
      d[2] <= DW'(origin[2]) - DW'(center_z);
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (cmd.find_step[a]) begin
          idx[a] <= idx[a] + 1'b1;
          d[a]   <= d[a] + step_s;
        end
      end
      if (cmd.lock) begin
        for (int a = 0; a < 3; a++) begin
          lo_idx[a] <= idx[a];
          lo_d[a]   <= d[a];
        end
      end
      if (cmd.step_z) begin
        idx[2] <= idx[2] + 1'b1;
        d[2]   <= d[2] + step_s;
      end
      if (cmd.step_y) begin
        idx[1] <= idx[1] + 1'b1;
        d[1]   <= d[1] + step_s;
        idx[2] <= lo_idx[2];
        d[2]   <= lo_d[2];
      end
      if (cmd.step_x) begin
        idx[0] <= idx[0] + 1'b1;
        d[0]   <= d[0] + step_s;
        idx[1] <= lo_idx[1];
        d[1]   <= lo_d[1];
        idx[2] <= lo_idx[2];
        d[2]   <= lo_d[2];
      end
    end
  end

  // Squares, their sum, then one root bit per cycle.
  assign rem_t = {rem[sdg_pkg::REM_W-3:0], rad[sdg_pkg::SQ_W-1 -: 2]};
  assign trial = sdg_pkg::REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      for (int a = 0; a < 3; a++) begin
        logic [DW-1:0] mag;
        mag = d[a][DW-1] ? DW'(-d[a]) : DW'(d[a]);
        sqr[a] <= mag[sdg_pkg::MAG_W-1:0] * mag[sdg_pkg::MAG_W-1:0];
      end
    end
    if (cmd.sum) begin
      rad  <= sdg_pkg::SQ_W'(sqr[0]) + sdg_pkg::SQ_W'(sqr[1]) + sdg_pkg::SQ_W'(sqr[2]);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= rad << 2;
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[sdg_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[sdg_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // The remainder above the root means the true root lies past the half step.
  assign q_round = (sdg_pkg::ROOT_W + 1)'(root) +
                   (sdg_pkg::ROOT_W + 1)'(rem > sdg_pkg::REM_W'(root));
  assign val = $signed({1'b0, q_round}) - $signed((sdg_pkg::ROOT_W + 2)'(radius));
  assign val_sat = (val > $signed((sdg_pkg::ROOT_W + 2)'(32767))) ? sdg_pkg::EMPTY_DIST :
                   val[sdg_pkg::DIST_W-1:0];
  assign better = val_sat < $signed(rd_data[sdg_pkg::ENTRY_W-1 -: sdg_pkg::DIST_W]);

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_init) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end

  always_comb begin
    case (cmd.addr_sel)
      sdg_pkg::ADDR_CLR: addr = clr_cnt;
      sdg_pkg::ADDR_RD:  addr = sdg_pkg::cell_addr(rx, ry, rz);
      default:           addr = sdg_pkg::cell_addr(idx[0], idx[1], idx[2]);
    endcase
  end

  assign we    = cmd.clr_step || (cmd.write && better);
  assign wdata = cmd.clr_step ? {sdg_pkg::EMPTY_DIST, sdg_pkg::NO_OWNER} :
                 {val_sat, sdg_pkg::OWN_W'(owner)};

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_data <= mem[addr];
  end

  assign cell_distance = rd_ok ? rd_data[sdg_pkg::ENTRY_W-1 -: sdg_pkg::DIST_W] :
                         sdg_pkg::EMPTY_DIST;
  assign cell_owner    = rd_ok ? rd_data[sdg_pkg::OWN_W-1:0] : sdg_pkg::NO_OWNER;

endmodule

// ===== sv/sphere_min_distance_grid_splat.sv =====
// Top level of the signed distance grid built from a union of balls.
//
//   channel   signals                                   handshake
//   item in   start, op, center_*, ball_*, read_*       start && !busy
//   result    result_valid, cell_distance, cell_owner   one-cycle strobe
//   config    cfg_valid, cfg_index, cfg_data            cfg_valid && cfg_ready
//
// A read gives its result in S_OUT, after S_RD. A ball steps each axis that
// lies below the box to find the box corner, then squares, sums, roots and
// compares per visited cell: the serial square root unit yields one root bit
// per cycle. A clear, and reset, sweep the grid memory one cell a cycle with
// busy high. Results cannot be stalled; configuration is always ready.
module sphere_min_distance_grid_splat (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           op,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_x,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_y,
  input  logic signed [sdg_pkg::COORD_W-1:0]   center_z,
  input  logic [sdg_pkg::RAD_W-1:0]            ball_radius,
  input  logic [sdg_pkg::OWNER_BITS-1:0]       ball_owner,
  input  logic [sdg_pkg::IDX_W-1:0]            read_x,
  input  logic [sdg_pkg::IDX_W-1:0]            read_y,
  input  logic [sdg_pkg::IDX_W-1:0]            read_z,
  output logic                                 result_valid,
  output logic signed [sdg_pkg::DIST_W-1:0]    cell_distance,
  output logic signed [sdg_pkg::OWN_W-1:0]     cell_owner,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sdg_pkg::CFG_W-1:0]            cfg_index,
  input  logic [sdg_pkg::DATA_W-1:0]           cfg_data
);

  sdg_pkg::cmd_t    cmd;
  sdg_pkg::status_t st;

  assign cfg_ready = 1'b1;

  sdg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .st           (st),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  sdg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .ball_radius   (ball_radius),
    .ball_owner    (ball_owner),
    .read_x        (read_x),
    .read_y        (read_y),
    .read_z        (read_z),
    .cell_distance (cell_distance),
    .cell_owner    (cell_owner)
  );

endmodule

// ===== sv/sdg_checker.sv =====
// Port-level checker for the signed distance grid block, with its bind.
module sdg_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       result_valid
);

  // A read transaction answers in S_OUT, after the controller passes through S_RD.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == sdg_pkg::OP_READ) |-> ##2 result_valid)
    else $error("read result missing");

  // Other transactions never produce a result right after acceptance.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op != sdg_pkg::OP_READ) |=> !result_valid)
    else $error("unexpected result");

  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result repeated");

  // The grid sweep after reset keeps the block busy.
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind sphere_min_distance_grid_splat sdg_checker u_sdg_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .result_valid (result_valid)
);

// ===== sim/tb_sphere_min_distance_grid_splat.sv =====
// Self-checking testbench for the ball-union signed distance grid.
module tb_sphere_min_distance_grid_splat;
  import sdg_pkg::*;

  typedef struct {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [RAD_W-1:0]          rad;
    logic [OWNER_BITS-1:0]     own;
    logic [IDX_W-1:0]          rx, ry, rz;
  } grid_cmd_t;

  typedef struct {
    logic signed [DIST_W-1:0] dval;
    logic [OWN_W-1:0]         owner;
  } cell_word_t;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] idx;
    logic [DATA_W-1:0] data;
    grid_cmd_t        cmd;
    bit               typed;
    cell_word_t       want;
  } stim_row_t;

  typedef struct {
    longint ox, oy, oz, spc;
    int     ex, ey, ez;
    int     rmax;
    bit     no_gaps;
  } phase_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_NOP;
  logic signed [COORD_W-1:0] center_x = '0, center_y = '0, center_z = '0;
  logic [RAD_W-1:0] ball_radius = '0;
  logic [OWNER_BITS-1:0] ball_owner = '0;
  logic [IDX_W-1:0] read_x = '0, read_y = '0, read_z = '0;
  logic result_valid;
  logic signed [DIST_W-1:0] cell_distance;
  logic signed [OWN_W-1:0] cell_owner;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  sphere_min_distance_grid_splat DUT (.*);

  always #5 clk = ~clk;

  // Mirror of the grid and its registers.
  logic signed [DIST_W-1:0] dist_mem [CELLS];
  logic [OWN_W-1:0]         own_mem [CELLS];
  longint org [3];
  longint spacing_reg;
  int     extent_reg [3];

  cell_word_t pending_reads [$];
  int errors = 0;
  int n_balls = 0, n_reads = 0, n_items = 0, n_results = 0;

  function automatic int eff_ext(int e);
    if (e == 0) return 1;
    if (e > 64) return 64;
    return e;
  endfunction

  function automatic longint floor_quot(longint n, longint s);
    longint q;
    q = n / s;
    if (n % s != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < CELLS; i++) begin
      dist_mem[i] = EMPTY_DIST;
      own_mem[i] = NO_OWNER;
    end
  endfunction

  function automatic void splat_mirror(grid_cmd_t c);
    longint ctr [3];
    longint lo [3], hi [3];
    longint s, r, dx, dy, dz, sq, q, val;
    int idx;
    ctr[0] = c.cx; ctr[1] = c.cy; ctr[2] = c.cz;
    r = c.rad;
    s = (spacing_reg == 0) ? 1 : spacing_reg;
    for (int a = 0; a < 3; a++) begin
      lo[a] = floor_quot(ctr[a] - org[a] - r, s) - 2;
      hi[a] = -floor_quot(-(ctr[a] - org[a] + r), s) + 2;
      if (lo[a] < 0) lo[a] = 0;
      if (hi[a] > eff_ext(extent_reg[a]) - 1) hi[a] = eff_ext(extent_reg[a]) - 1;
    end
    for (longint x = lo[0]; x <= hi[0]; x++) begin
      dx = org[0] + x * s - ctr[0];
      for (longint y = lo[1]; y <= hi[1]; y++) begin
        dy = org[1] + y * s - ctr[1];
        for (longint z = lo[2]; z <= hi[2]; z++) begin
          dz = org[2] + z * s - ctr[2];
          sq = dx * dx + dy * dy + dz * dz;
          q = int_sqrt(sq);
          if (sq > q * q + q) q++;
          val = q - r;
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
          idx = int'((x * GRID_Y_MAX + y) * GRID_Z_MAX + z);
          if (val < longint'(dist_mem[idx])) begin
            dist_mem[idx] = DIST_W'(val);
            own_mem[idx] = OWN_W'(c.own);
          end
        end
      end
    end
  endfunction

  function automatic cell_word_t read_mirror(grid_cmd_t c);
    cell_word_t w;
    int idx;
    w.dval = EMPTY_DIST;
    w.owner = NO_OWNER;
    if (c.rx < eff_ext(extent_reg[0]) && c.ry < eff_ext(extent_reg[1]) &&
        c.rz < eff_ext(extent_reg[2])) begin
      idx = (int'(c.rx) * GRID_Y_MAX + int'(c.ry)) * GRID_Z_MAX + int'(c.rz);
      w.dval = dist_mem[idx];
      w.owner = own_mem[idx];
    end
    return w;
  endfunction

  // Drives one command and updates the mirror once the block takes it.
  task automatic issue_cmd(grid_cmd_t c, bit gaps, bit typed, cell_word_t want);
    cell_word_t exp_w;
    if (gaps && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    op <= c.op;
    center_x <= c.cx; center_y <= c.cy; center_z <= c.cz;
    ball_radius <= c.rad;
    ball_owner <= c.own;
    read_x <= c.rx; read_y <= c.ry; read_z <= c.rz;
    do @(posedge clk); while (busy !== 1'b0);
    n_items++;
    case (c.op)
      OP_CLEAR: clear_mirror();
      OP_SPLAT: begin
        splat_mirror(c);
        n_balls++;
      end
      OP_READ: begin
        exp_w = typed ? want : read_mirror(c);
        pending_reads = {pending_reads, exp_w};
        n_reads++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_W-1:0] idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DATA_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_ORIGIN_X: org[0] = longint'($signed(COORD_W'(value)));
      CFG_ORIGIN_Y: org[1] = longint'($signed(COORD_W'(value)));
      CFG_ORIGIN_Z: org[2] = longint'($signed(COORD_W'(value)));
      CFG_SPACING:  spacing_reg = value & 12'hFFF;
      CFG_EXTENT_X: extent_reg[0] = int'(value & 7'h7F);
      CFG_EXTENT_Y: extent_reg[1] = int'(value & 7'h7F);
      CFG_EXTENT_Z: extent_reg[2] = int'(value & 7'h7F);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cell_word_t w;
    if (!rst && result_valid === 1'b1) begin
      n_results++;
      if (pending_reads.size() == 0) begin
        $error("cell read result with no read outstanding");
        errors++;
      end else begin
        w = pending_reads.pop_front();
        if (cell_distance !== w.dval) begin
          $error("cell_distance: expected %0d, got %0d", w.dval, cell_distance);
          errors++;
        end
        if (cell_owner !== w.owner) begin
          $error("cell_owner: expected %0h, got %0h", w.owner, cell_owner);
          errors++;
        end
      end
    end
  end

  function automatic stim_row_t read_row(int x, int y, int z, bit typed,
                                         int d, longint o);
    stim_row_t r;
    r = '{default: '0};
    r.cmd.op = OP_READ;
    r.cmd.rx = x; r.cmd.ry = y; r.cmd.rz = z;
    r.typed = typed;
    r.want.dval = DIST_W'(d);
    r.want.owner = OWN_W'(o);
    return r;
  endfunction

  function automatic stim_row_t ball_row(int x, int y, int z, int rad, int own);
    stim_row_t r;
    r = '{default: '0};
    r.cmd.op = OP_SPLAT;
    r.cmd.cx = x; r.cmd.cy = y; r.cmd.cz = z;
    r.cmd.rad = rad;
    r.cmd.own = own;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_W-1:0] idx, int value);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = value;
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [1:0] code);
    stim_row_t r;
    r = '{default: '0};
    r.cmd.op = code;
    return r;
  endfunction

  initial begin
    stim_row_t  rows [$];
    phase_cfg_t phases [6];
    grid_cmd_t  c;
    cell_word_t none;
    longint s, off;
    int e [3];
    int pick;
    bit in_cfg;

    none = '{default: '0};
    org = '{0, 0, 0};
    spacing_reg = 128;
    extent_reg = '{64, 64, 64};
    clear_mirror();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);

    // Empty grid after reset, a ball at the origin, ties, far balls, extents, a no-op and a clear.
    rows = {rows, read_row(0, 0, 0, 1, 32767, -1)};
    rows = {rows, read_row(63, 63, 63, 1, 32767, -1)};
    rows = {rows, ball_row(0, 0, 0, 0, 24'hFFFFFF)};
    rows = {rows, read_row(0, 0, 0, 1, 0, 24'hFFFFFF)};
    rows = {rows, read_row(2, 1, 0, 0, 0, 0)};
    rows = {rows, ball_row(0, 0, 0, 0, 5)};
    rows = {rows, read_row(0, 0, 0, 1, 0, 24'hFFFFFF)};
    rows = {rows, cfg_row(CFG_EXTENT_X, 4)};
    rows = {rows, cfg_row(CFG_EXTENT_Y, 4)};
    rows = {rows, cfg_row(CFG_EXTENT_Z, 4)};
    rows = {rows, ball_row(256, 0, 0, 4095, 0)};
    rows = {rows, read_row(1, 0, 0, 0, 0, 0)};
    rows = {rows, read_row(5, 0, 0, 1, 32767, -1)};
    rows = {rows, ball_row(-8388608, -8388608, -8388608, 4095, 9)};
    rows = {rows, ball_row(8388607, 8388607, 8388607, 4095, 9)};
    rows = {rows, op_row(OP_NOP)};
    rows = {rows, read_row(3, 3, 3, 0, 0, 0)};
    rows = {rows, cfg_row(CFG_EXTENT_X, 0)};
    rows = {rows, read_row(1, 0, 0, 1, 32767, -1)};
    rows = {rows, read_row(0, 1, 1, 0, 0, 0)};
    rows = {rows, cfg_row(CFG_EXTENT_X, 127)};
    rows = {rows, read_row(63, 0, 0, 0, 0, 0)};
    rows = {rows, op_row(OP_CLEAR)};
    rows = {rows, read_row(0, 0, 0, 1, 32767, -1)};

    in_cfg = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        issue_cmd(rows[i].cmd, 1'b1, rows[i].typed, rows[i].want);
      end
    end

    // Register settings per random phase; extents stay small where the
    // spacing is fine so that each ball visits a bounded number of cells.
    phases[0] = '{0, 0, 0, 128, 4, 4, 4, 4095, 0};
    phases[1] = '{-8388608, 8088607, 1000, 4095, 64, 127, 64, 200, 0};
    phases[2] = '{8388607, -8388608, 8388607, 1, 3, 5, 2, 4095, 1};
    phases[3] = '{12345, -777, -40000, 0, 0, 1, 6, 50, 0};
    phases[4] = '{0, 0, 0, 300, 5, 5, 5, 4095, 0};
    phases[5] = '{0, 0, 0, 128, 64, 64, 64, 100, 0};
    phases[4].ox = $signed(24'($urandom));
    phases[4].oy = $signed(24'($urandom));
    phases[4].oz = $signed(24'($urandom));

    foreach (phases[p]) begin
      wait_idle();
      write_reg(CFG_ORIGIN_X, phases[p].ox);
      write_reg(CFG_ORIGIN_Y, phases[p].oy);
      write_reg(CFG_ORIGIN_Z, phases[p].oz);
      write_reg(CFG_SPACING, phases[p].spc);
      write_reg(CFG_EXTENT_X, phases[p].ex);
      write_reg(CFG_EXTENT_Y, phases[p].ey);
      write_reg(CFG_EXTENT_Z, phases[p].ez);
      cfg_valid <= 1'b0;
      s = (spacing_reg == 0) ? 1 : spacing_reg;
      for (int a = 0; a < 3; a++) e[a] = eff_ext(extent_reg[a]);
      repeat (50) begin
        c = '{default: '0};
        c.own = $urandom;
        c.rx = $urandom; c.ry = $urandom; c.rz = $urandom;
        c.rad = $urandom_range(0, phases[p].rmax);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          c.op = OP_SPLAT;
          if ($urandom_range(0, 9) == 0) begin
            c.cx = $urandom; c.cy = $urandom; c.cz = $urandom;
          end else begin
            off = longint'($urandom_range(0, (e[0] + 6) * s + 2 * c.rad)) - 3 * s - c.rad;
            c.cx = COORD_W'(org[0] + off);
            off = longint'($urandom_range(0, (e[1] + 6) * s + 2 * c.rad)) - 3 * s - c.rad;
            c.cy = COORD_W'(org[1] + off);
            off = longint'($urandom_range(0, (e[2] + 6) * s + 2 * c.rad)) - 3 * s - c.rad;
            c.cz = COORD_W'(org[2] + off);
          end
        end else if (pick < 90) begin
          c.op = OP_READ;
          if ($urandom_range(0, 9) < 6) begin
            c.rx = $urandom_range(0, e[0] - 1);
            c.ry = $urandom_range(0, e[1] - 1);
            c.rz = $urandom_range(0, e[2] - 1);
          end
        end else begin
          c.op = OP_NOP;
          c.cx = $urandom; c.cy = $urandom; c.cz = $urandom;
        end
        issue_cmd(c, !phases[p].no_gaps, 1'b0, none);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d commands: %0d balls and %0d cell reads (%0d results checked)",
             n_items, n_balls, n_reads, n_results);
    $display("over %0d register settings, including extreme origins, spacings and extents.",
             7);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("** sphere_min_distance_grid_splat: PASSED **");
    end else begin
      $display("** sphere_min_distance_grid_splat: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("** sphere_min_distance_grid_splat: FAILED **");
    $finish;
  end

endmodule

// ===== sphere_min_distance_grid_splat.f =====
sv/sdg_pkg.sv
sv/sdg_ctrl.sv
sv/sdg_dp.sv
sv/sphere_min_distance_grid_splat.sv
sv/sdg_checker.sv
sim/tb_sphere_min_distance_grid_splat.sv
